>>> rtl/iir_etd_pkg.sv
package iir_etd_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 40;
  localparam int unsigned THR_W       = 32;
  localparam int unsigned ENERGY_W    = 52;
  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned LEN_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned HALF_W      = LEN_W - 1;
  localparam int unsigned HIST_DEPTH  = 4;
  localparam int unsigned HIST_IDX_W  = $clog2(HIST_DEPTH);
  localparam int unsigned TAP_W       = $clog2(HIST_DEPTH + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);

  // shared multiplier: coefficient times a 25 bit slice
  localparam int unsigned MUL_B_W  = 25;
  localparam int unsigned MUL_W    = COEF_W + MUL_B_W;
  localparam int unsigned Y_SPLIT  = MUL_B_W - 1;
  localparam int unsigned PART_W   = 2 * COEF_W;
  localparam int unsigned ACC_W    = 57;
  localparam int unsigned IP_W     = COEF_W - 16;
  localparam int unsigned SQ_W     = 2 * IP_W;
  localparam int unsigned THRP_W   = THR_W + HALF_W;
  localparam int unsigned B_SHIFT  = 12;
  localparam int unsigned A_SHIFT  = 28;
  localparam int unsigned Y_SHIFT  = 8;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned LAST_ISSUE_STEP = 12;
  localparam int unsigned LAST_MAC_STEP   = 14;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_B_OUTER   = 3'd1,
    REG_B_INNER   = 3'd2,
    REG_B_CENTER  = 3'd3,
    REG_A1        = 3'd4,
    REG_A2        = 3'd5,
    REG_A3        = 3'd6,
    REG_A4        = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_B    = 3'd1,
    OP_ALO  = 3'd2,
    OP_AHI  = 3'd3,
    OP_SQ   = 3'd4
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [TAP_W-1:0] tap;
  } op_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [QLEVEL_W-1:0] level;
    logic                full;
  } queue_status_t;

  typedef struct packed {
    logic [THR_W-1:0]                 threshold;
    logic [COEF_W-1:0]                b_outer;
    logic [COEF_W-1:0]                b_inner;
    logic [COEF_W-1:0]                b_center;
    logic [HIST_DEPTH-1:0][COEF_W-1:0] a;
  } coef_t;

  typedef struct packed {
    logic [LEN_W-1:0]    buffer_length;
    logic [ENERGY_W-1:0] energy;
    logic                detected;
  } result_t;

  // issue order of the shared multiplier within one sample
  function automatic op_t sched(logic [STEP_W-1:0] step);
    op_t op;
    op.kind = OP_NONE;
    op.tap  = '0;
    case (step)
      4'd0:  begin op.kind = OP_B;   op.tap = 3'd0; end
      4'd1:  begin op.kind = OP_B;   op.tap = 3'd1; end
      4'd2:  begin op.kind = OP_B;   op.tap = 3'd2; end
      4'd3:  begin op.kind = OP_B;   op.tap = 3'd3; end
      4'd4:  begin op.kind = OP_B;   op.tap = 3'd4; end
      4'd5:  begin op.kind = OP_ALO; op.tap = 3'd1; end
      4'd6:  begin op.kind = OP_AHI; op.tap = 3'd1; end
      4'd7:  begin op.kind = OP_ALO; op.tap = 3'd2; end
      4'd8:  begin op.kind = OP_AHI; op.tap = 3'd2; end
      4'd9:  begin op.kind = OP_ALO; op.tap = 3'd3; end
      4'd10: begin op.kind = OP_AHI; op.tap = 3'd3; end
      4'd11: begin op.kind = OP_ALO; op.tap = 3'd4; end
      4'd12: begin op.kind = OP_AHI; op.tap = 3'd4; end
      default: begin op.kind = OP_NONE; op.tap = '0; end
    endcase
    return op;
  endfunction

endpackage

>>> rtl/iir_etd_front.sv
module iir_etd_front
  import iir_etd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  item_t         in_item_i,
  output logic          out_valid_o,
  output item_t         out_item_o,
  input  logic          pop_i,
  output queue_status_t status_o
);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QLEVEL_W-1:0]  level_q, level_d;
  logic                 push, pop;

  assign in_ready_o  = (level_q != QLEVEL_W'(QUEUE_DEPTH));
  assign out_valid_o = (level_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_i && out_valid_o;

  assign status_o.level = level_q;
  assign status_o.full  = !in_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      level_d = level_q + 1'b1;
    end else if (pop && !push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

>>> rtl/iir_etd_back.sv
module iir_etd_back
  import iir_etd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  coef_t   coef_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MAC    = 6'b000010,
    S_YCALC  = 6'b000100,
    S_SQR    = 6'b001000,
    S_ENERGY = 6'b010000,
    S_FINISH = 6'b100000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [SAMPLE_W-1:0] x_cur_q;
  logic                last_q;
  logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] x_hist_q, x_hist_d;
  logic [HIST_DEPTH-1:0][COEF_W-1:0]   y_hist_q, y_hist_d;
  logic [COEF_W-1:0]   y_q;

  op_t                     op;
  logic [HIST_IDX_W-1:0]   hidx;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_q;
  op_kind_e                  kind_q;
  logic signed [PART_W-1:0]  part_q, part_d;
  logic                      apend_q, apend_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d, addend;
  logic signed [MUL_W-1:0]   b_term;
  logic signed [PART_W-1:0]  a_term;

  logic signed [ACC_W-1:0]   y_full;
  logic [COEF_W-1:0]         y_sat;
  logic [COEF_W-1:0]         y_mag;
  logic [IP_W-1:0]           ip;

  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [ENERGY_W:0]   energy_sum;
  logic [LEN_W-1:0]    count_q, count_d, count_next;
  logic [THRP_W-1:0]   thr_prod_q;
  logic                detected;
  logic                res_valid_q, res_valid_d;
  result_t             res_q;
  logic                load_res;

  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'sd549755813887);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-64'sd549755813888);

  assign hidx = HIST_IDX_W'(op.tap - 1'b1);

  // operand selection for the shared multiplier
  always_comb begin
    op = sched(step_q);
    if (state_q != S_MAC) begin
      op.kind = OP_NONE;
    end
    if (state_q == S_SQR) begin
      op.kind = OP_SQ;
    end
    mul_a = '0;
    mul_b = '0;
    case (op.kind)
      OP_B: begin
        case (op.tap)
          3'd0, 3'd4: mul_a = $signed(coef_i.b_outer);
          3'd1, 3'd3: mul_a = $signed(coef_i.b_inner);
          3'd2:       mul_a = $signed(coef_i.b_center);
          default:    mul_a = '0;
        endcase
        if (op.tap == '0) begin
          mul_b = MUL_B_W'($signed(x_cur_q));
        end else begin
          mul_b = MUL_B_W'($signed(x_hist_q[hidx]));
        end
      end
      OP_ALO: begin
        mul_a = $signed(coef_i.a[hidx]);
        mul_b = $signed({1'b0, y_hist_q[hidx][Y_SPLIT-1:0]});
      end
      OP_AHI: begin
        mul_a = $signed(coef_i.a[hidx]);
        mul_b = MUL_B_W'($signed(y_hist_q[hidx][COEF_W-1:Y_SPLIT]));
      end
      OP_SQ: begin
        mul_a = $signed({{(COEF_W-IP_W){1'b0}}, ip});
        mul_b = $signed({1'b0, ip});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // accumulate: b products floored to q.24 directly, a products after both halves
  // feedback terms are subtracted
  assign b_term = mul_q >>> B_SHIFT;
  assign a_term = part_q >>> A_SHIFT;

  always_comb begin
    part_d  = part_q;
    apend_d = 1'b0;
    addend  = '0;
    case (kind_q)
      OP_B:   addend = b_term[ACC_W-1:0];
      OP_ALO: part_d = PART_W'(mul_q);
      OP_AHI: begin
        part_d  = part_q + (PART_W'(mul_q) <<< Y_SPLIT);
        apend_d = 1'b1;
      end
      default: part_d = part_q;
    endcase
    if (apend_q) begin
      addend = '0 - a_term[ACC_W-1:0];
    end
    acc_d = acc_q + addend;
    if (state_q == S_IDLE) begin
      acc_d = '0;
    end
  end

  // filter output: floor by 2^8 then clamp to 40 bits
  always_comb begin
    y_full = acc_q >>> Y_SHIFT;
    if (y_full > Y_MAX) begin
      y_sat = Y_MAX[COEF_W-1:0];
    end else if (y_full < Y_MIN) begin
      y_sat = Y_MIN[COEF_W-1:0];
    end else begin
      y_sat = y_full[COEF_W-1:0];
    end
  end

  assign y_mag = y_q[COEF_W-1] ? (~y_q + 1'b1) : y_q;
  assign ip    = y_mag[COEF_W-1:COEF_W-IP_W];

  assign count_next = (count_q < LEN_W'(MAX_SAMPLES)) ? count_q + 1'b1 : count_q;
  assign energy_sum = {1'b0, energy_q} + (ENERGY_W+1)'(mul_q[SQ_W-1:0]);

  always_comb begin
    if (count_q[LEN_W-1:1] == '0) begin
      detected = (energy_q != '0);
    end else begin
      detected = (energy_q >= ENERGY_W'(thr_prod_q));
    end
  end

  assign pop_o    = (state_q == S_IDLE) && item_valid_i;
  assign load_res = (state_q == S_FINISH) && (!res_valid_q || res_ready_i);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    x_hist_d = x_hist_q;
    y_hist_d = y_hist_q;
    energy_d = energy_q;
    count_d  = count_q;
    case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (item_valid_i) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(LAST_MAC_STEP)) begin
          state_d = S_YCALC;
        end
      end
      S_YCALC: begin
        x_hist_d = {x_hist_q[HIST_DEPTH-2:0], x_cur_q};
        y_hist_d = {y_hist_q[HIST_DEPTH-2:0], y_sat};
        state_d  = S_SQR;
      end
      S_SQR: begin
        state_d = S_ENERGY;
      end
      S_ENERGY: begin
        energy_d = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
        count_d  = count_next;
        state_d  = last_q ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (load_res) begin
          x_hist_d = '0;
          y_hist_d = '0;
          energy_d = '0;
          count_d  = '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (load_res) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      kind_q      <= OP_NONE;
      apend_q     <= 1'b0;
      x_hist_q    <= '0;
      y_hist_q    <= '0;
      energy_q    <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      kind_q      <= op.kind;
      apend_q     <= apend_d;
      x_hist_q    <= x_hist_d;
      y_hist_q    <= y_hist_d;
      energy_q    <= energy_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    acc_q  <= acc_d;
    if (pop_o) begin
      x_cur_q <= item_i.sample;
      last_q  <= item_i.last;
    end
    if (state_q == S_YCALC) begin
      y_q        <= y_sat;
      thr_prod_q <= THRP_W'(coef_i.threshold) * THRP_W'(count_next[LEN_W-1:1]);
    end
    if (load_res) begin
      res_q.detected      <= detected;
      res_q.energy        <= energy_q;
      res_q.buffer_length <= count_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/iir_energy_transmission_detector.sv
// Fourth-order IIR lowpass energy detector. Samples enter on s_axis (tlast closes a buffer)
// into a two-entry queue, so the port keeps taking samples while the filter works. Each
// sample then passes through the filter engine, which holds one sample at a time and uses
// its one shared 40x25 multiplier for five numerator products and eight half products for
// the four feedback taps; after the drain of that pipeline and the output clamp, it squares
// the integer part. The sample that closes a buffer then produces one result on m_axis;
// it holds there while the output register is still occupied. Configuration writes are
// accepted in every cycle and belong only to idle periods.
module iir_energy_transmission_detector
  import iir_etd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] detected, [52:1] energy,
                                                 // [69:53] buffer_length, rest zero
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [COEF_W-1:0]      cfg_data_i
);

  coef_t         coef_q;
  item_t         in_item;
  item_t         q_item;
  logic          q_valid;
  logic          q_pop;
  queue_status_t q_status;
  result_t       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.threshold <= THR_W'(1000);
      coef_q.b_outer   <= COEF_W'(64'sd386203);
      coef_q.b_inner   <= COEF_W'(64'sd1544127);
      coef_q.b_center  <= COEF_W'(64'sd2315846);
      coef_q.a[0]      <= COEF_W'(-64'sd256832172353);
      coef_q.a[1]      <= COEF_W'(64'sd360502374957);
      coef_q.a[2]      <= COEF_W'(-64'sd225221213055);
      coef_q.a[3]      <= COEF_W'(64'sd52838405662);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_THRESHOLD: coef_q.threshold <= cfg_data_i[THR_W-1:0];
        REG_B_OUTER:   coef_q.b_outer   <= cfg_data_i;
        REG_B_INNER:   coef_q.b_inner   <= cfg_data_i;
        REG_B_CENTER:  coef_q.b_center  <= cfg_data_i;
        REG_A1:        coef_q.a[0]      <= cfg_data_i;
        REG_A2:        coef_q.a[1]      <= cfg_data_i;
        REG_A3:        coef_q.a[2]      <= cfg_data_i;
        REG_A4:        coef_q.a[3]      <= cfg_data_i;
        default:       coef_q           <= coef_q;
      endcase
    end
  end

  assign in_item.sample = s_axis_tdata[SAMPLE_W-1:0];
  assign in_item.last   = s_axis_tlast;

  iir_etd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_item_o  (q_item),
    .pop_i       (q_pop),
    .status_o    (q_status)
  );

  iir_etd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (coef_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res);

`ifndef NO_ASSERTIONS
  // the engine only takes a sample that the queue holds
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("sample taken from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.level <= QLEVEL_W'(QUEUE_DEPTH))
    else $error("queue level beyond depth");

  // a result always closes a buffer of at least one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (res.buffer_length != '0))
    else $error("result with empty buffer");
`endif

endmodule
